FILE: rtl/bkpe_pkg.sv
// types, constants and codes shared by the boot keyboard press extractor
// no dependencies

package bkpe_pkg;

  localparam int SLOT_FIELDS  = 6;
  localparam int KEY_SLOTS    = 6;
  localparam int ACTIVE_SLOTS = (KEY_SLOTS > SLOT_FIELDS) ? SLOT_FIELDS : KEY_SLOTS;

  localparam logic [7:0] FIRST_REAL_CODE   = 8'd4;
  localparam logic [3:0] FULL_REPORT_BYTES = 4'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic       MODE_REPORT      = 1'b0;
  localparam logic       MODE_ATTACH      = 1'b1;
  localparam logic [1:0] STATUS_COMPLETED = 2'd0;

  typedef logic [7:0] code_t;
  typedef code_t [SLOT_FIELDS-1:0] codes_t;
  typedef logic [SLOT_FIELDS-1:0] slot_mask_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] transfer_status;
    logic [3:0] byte_count;
    logic [7:0] modifier_bits;
    logic [7:0] slot_code_0;
    logic [7:0] slot_code_1;
    logic [7:0] slot_code_2;
    logic [7:0] slot_code_3;
    logic [7:0] slot_code_4;
    logic [7:0] slot_code_5;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pressed_code;
    logic [7:0] event_modifiers;
    logic       last_event;
  } out_word_t;

  typedef struct packed {
    logic [7:0] modifiers;
    codes_t     codes;
    slot_mask_t mask;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } q_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: rtl/bkpe_front.sv
// front end: accepts reports, finds newly pressed slots, keeps the previous codes
// depends on bkpe_pkg

module bkpe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bkpe_pkg::in_word_t in_data,
  input  bkpe_pkg::q_status_t q_status,
  output bkpe_pkg::q_push_t  push
);

  bkpe_pkg::codes_t     prev;
  bkpe_pkg::codes_t     prev_next;
  bkpe_pkg::codes_t     codes;
  bkpe_pkg::slot_mask_t hits;
  bkpe_pkg::slot_mask_t new_mask;
  logic                 accept;
  logic                 report_ok;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign codes[0] = in_data.slot_code_0;
  assign codes[1] = in_data.slot_code_1;
  assign codes[2] = in_data.slot_code_2;
  assign codes[3] = in_data.slot_code_3;
  assign codes[4] = in_data.slot_code_4;
  assign codes[5] = in_data.slot_code_5;

  assign report_ok = (in_data.mode == bkpe_pkg::MODE_REPORT)
                  && (in_data.transfer_status == bkpe_pkg::STATUS_COMPLETED)
                  && (in_data.byte_count >= bkpe_pkg::FULL_REPORT_BYTES);

  always_comb begin
    hits     = '0;
    new_mask = '0;
    for (int i = 0; i < bkpe_pkg::SLOT_FIELDS; i++) begin
      for (int j = 0; j < bkpe_pkg::ACTIVE_SLOTS; j++) begin
        if (prev[j] == codes[i]) begin
          hits[i] = 1'b1;
        end
      end
      if (i < bkpe_pkg::ACTIVE_SLOTS) begin
        new_mask[i] = (codes[i] >= bkpe_pkg::FIRST_REAL_CODE) && !hits[i];
      end
    end
  end

  always_comb begin
    prev_next = prev;
    if (accept) begin
      if (in_data.mode == bkpe_pkg::MODE_ATTACH) begin
        prev_next = '0;
      end else if (report_ok) begin
        for (int i = 0; i < bkpe_pkg::ACTIVE_SLOTS; i++) begin
          prev_next[i] = codes[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else begin
      prev <= prev_next;
    end
  end

  assign push.valid           = accept && report_ok && (new_mask != '0);
  assign push.entry.modifiers = in_data.modifier_bits;
  assign push.entry.codes     = codes;
  assign push.entry.mask      = new_mask;

endmodule

FILE: rtl/bkpe_queue.sv
// short queue of classified reports between front and back
// depends on bkpe_pkg

module bkpe_queue (
  input  logic                clk,
  input  logic                rst,
  input  bkpe_pkg::q_push_t   push,
  input  logic                pop,
  output bkpe_pkg::qentry_t   head,
  output bkpe_pkg::q_status_t status
);

  bkpe_pkg::qentry_t                mem [bkpe_pkg::QUEUE_DEPTH];
  logic [bkpe_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bkpe_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bkpe_pkg::QCNT_W-1:0]      count;

  assign status.empty = (count == '0);
  assign status.full  = (count == bkpe_pkg::QCNT_W'(bkpe_pkg::QUEUE_DEPTH));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == bkpe_pkg::QPTR_W'(bkpe_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bkpe_pkg::QPTR_W'(bkpe_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !status.full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bkpe_pkg::QCNT_W'(bkpe_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: rtl/bkpe_back.sv
// back end: serializes the new slots of each queued report into press words
// depends on bkpe_pkg

module bkpe_back (
  input  logic                clk,
  input  logic                rst,
  input  bkpe_pkg::qentry_t   head,
  input  bkpe_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bkpe_pkg::out_word_t out_data
);

  logic [7:0]           cur_mods;
  bkpe_pkg::codes_t     cur_codes;
  bkpe_pkg::slot_mask_t cur_mask;
  bkpe_pkg::slot_mask_t pick;
  bkpe_pkg::slot_mask_t rest;
  logic [7:0]           pick_code;
  logic                 out_free;
  logic                 emit;
  logic                 need_load;

  // lowest pending slot
  assign pick = cur_mask & (~cur_mask + 1'b1);
  assign rest = cur_mask & ~pick;

  always_comb begin
    pick_code = '0;
    for (int i = 0; i < bkpe_pkg::SLOT_FIELDS; i++) begin
      pick_code = pick_code | (cur_codes[i] & {8{pick[i]}});
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign emit      = out_free && (cur_mask != '0);
  assign need_load = (cur_mask == '0) || (emit && (rest == '0));
  assign pop       = need_load && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_mask  <= '0;
    end else begin
      if (out_free) begin
        out_valid <= emit;
      end
      if (pop) begin
        cur_mask <= head.mask;
      end else if (emit) begin
        cur_mask <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_mods  <= head.modifiers;
      cur_codes <= head.codes;
    end
    if (emit) begin
      out_data.pressed_code    <= pick_code;
      out_data.event_modifiers <= cur_mods;
      out_data.last_event      <= (rest == '0);
    end
  end

`ifndef SYNTHESIS
  a_real_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pressed_code >= bkpe_pkg::FIRST_REAL_CODE))
    else $error("press word carries a code below the first real key");
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_event) |=> out_valid)
    else $error("press burst broken before its last word");
`endif

endmodule

FILE: rtl/boot_keyboard_press_extractor_top.sv
// top level of the boot keyboard press extractor
// depends on bkpe_pkg, bkpe_front, bkpe_queue, bkpe_back
// throughput: one report per cycle into a 4-entry queue while the queue is not
// full; the back end drains one press word per cycle while out_stall is low
// reset clears the stored key codes, the queue and the output valid flag

module boot_keyboard_press_extractor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bkpe_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bkpe_pkg::out_word_t out_data
);

  bkpe_pkg::q_push_t   push;
  bkpe_pkg::q_status_t q_status;
  bkpe_pkg::qentry_t   head;
  logic                pop;

  bkpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push)
  );

  bkpe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  bkpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
